// ===== src/hsla_pkg.sv =====
package hsla_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIT = 2'd2;

  localparam int ONE2 = 131070;
  localparam int HUE_FULL = 393216;
  localparam int PCT_DEN = 100;

  // Reciprocals for the constant divisions: floor(x / 100) for x below 2^24 and
  // floor(x / 131070) for x below 2^26.
  localparam logic [24:0] LIT_RCP = 25'd21474837;
  localparam int LIT_RSH = 31;
  localparam logic [26:0] BLD_RCP = 27'd67109889;
  localparam int BLD_RSH = 43;

  localparam int DIV_STEPS = 2;
  localparam int HUE_QW = 17;
  localparam int SAT_QW = 17;
  localparam int LIT_QW = 19;
  localparam int HUE_DS = (HUE_QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int SAT_DS = (SAT_QW + DIV_STEPS - 1) / DIV_STEPS;

  localparam int ST_CLASS = 0;
  localparam int ST_HDIV = ST_CLASS + 1;
  localparam int ST_RAW = ST_HDIV + HUE_DS;
  localparam int ST_PMUL = ST_RAW + 1;
  localparam int ST_REBUILD = ST_PMUL + 1;
  localparam int ST_SMUL = ST_REBUILD + 1;
  localparam int ST_SSET = ST_SMUL + 1;
  localparam int ST_SDIV = ST_SSET + 1;
  localparam int ST_SRES = ST_SDIV + SAT_DS;
  localparam int ST_LMUL = ST_SRES + 1;
  localparam int ST_LSET = ST_LMUL + 1;
  localparam int ST_LDIV = ST_LSET + 1;
  localparam int ST_LRES = ST_LDIV + 1;
  localparam int ST_BMUL = ST_LRES + 1;
  localparam int ST_BSET = ST_BMUL + 1;
  localparam int ST_BDIV = ST_BSET + 1;
  localparam int ST_CLAMP = ST_BDIV + 1;
  localparam int N_STAGES = ST_CLAMP + 1;

  typedef enum logic [1:0] {
    MSEL_RED   = 2'd0,
    MSEL_GREEN = 2'd1,
    MSEL_BLUE  = 2'd2
  } msel_e;

  typedef struct packed {
    logic [18:0]       shift;
    logic signed [7:0] sat;
    logic signed [7:0] lit;
  } cfg_t;

  typedef struct packed {
    logic [35:0]       num;
    logic [LIT_QW-1:0] quo;
    logic              neg;
  } dlane_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              ach;
    logic [7:0]        mx;
    logic [7:0]        mn;
    msel_e             msel;
    logic [15:0]       d;
    logic [18:0]       h;
    logic [15:0]       p;
    logic [2:0][15:0]  c;
    logic [16:0]       v;
    logic [16:0]       kk;
    logic [2:0][34:0]  prod;
    logic [2:0][16:0]  t;
    logic [16:0]       den;
    dlane_t [2:0]      dl;
  } pipe_t;

  function automatic pipe_t div_steps(input pipe_t x, input int hi);
    pipe_t y;
    logic [35:0] sh;
    int b;
    y = x;
    for (int j = 0; j < DIV_STEPS; j++) begin
      b = hi - j;
      if (b >= 0) begin
        sh = 36'(y.den) << b;
        for (int i = 0; i < 3; i++) begin
          if (y.dl[i].num >= sh) begin
            y.dl[i].num = y.dl[i].num - sh;
            y.dl[i].quo[5'(b)] = 1'b1;
          end
        end
      end
    end
    return y;
  endfunction

  function automatic logic [7:0] chan(input pipe_t x, input int i);
    logic [7:0] r;
    if (i == 0) begin
      r = x.red;
    end else if (i == 1) begin
      r = x.green;
    end else begin
      r = x.blue;
    end
    return r;
  endfunction

  function automatic pipe_t stage_fn(input int k, input pipe_t x, input cfg_t cf);
    pipe_t y;
    logic [8:0] diff;
    logic [7:0] mag;
    logic [15:0] dd;
    logic [20:0] raw;
    logic [20:0] hh;
    logic [20:0] base;
    logic [32:0] pm;
    logic [15:0] mm;
    logic [15:0] mxx;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [16:0] dcap;
    logic [23:0] lhs;
    logic [23:0] rhs;
    logic [7:0] kpos;
    logic [7:0] kneg;
    logic [17:0] e;
    logic [17:0] em;
    logic [17:0] tt;
    logic [7:0] lk;
    logic [9:0] q;
    logic [48:0] lq;
    logic [52:0] bq;
    y = x;
    diff = '0;
    if (k == ST_CLASS) begin
      y.mx = x.red;
      if (x.green > y.mx) y.mx = x.green;
      if (x.blue > y.mx) y.mx = x.blue;
      y.mn = x.red;
      if (x.green < y.mn) y.mn = x.green;
      if (x.blue < y.mn) y.mn = x.blue;
      if (x.red == y.mx) begin
        y.msel = MSEL_RED;
      end else if (x.green == y.mx) begin
        y.msel = MSEL_GREEN;
      end else begin
        y.msel = MSEL_BLUE;
      end
      unique case (y.msel)
        MSEL_RED:   diff = {1'b0, x.green} - {1'b0, x.blue};
        MSEL_GREEN: diff = {1'b0, x.blue} - {1'b0, x.red};
        MSEL_BLUE:  diff = {1'b0, x.red} - {1'b0, x.green};
        default:    diff = '0;
      endcase
      mag = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
      dd = {8'(y.mx - y.mn), 8'(y.mx - y.mn)};
      y.d = dd;
      y.ach = (y.mx == y.mn);
      y.den = {1'b0, dd};
      y.dl = '0;
      y.dl[0].neg = diff[8];
      y.dl[0].num = {4'b0, mag, mag, 16'b0} + 36'(dd[15:1]);
    end else if (k >= ST_HDIV && k < ST_RAW) begin
      y = div_steps(x, HUE_QW - 1 - DIV_STEPS * (k - ST_HDIV));
    end else if (k == ST_RAW) begin
      unique case (x.msel)
        MSEL_RED:   base = 21'd0;
        MSEL_GREEN: base = 21'(2 * 65536);
        MSEL_BLUE:  base = 21'(4 * 65536);
        default:    base = 21'd0;
      endcase
      raw = x.dl[0].neg ? base - 21'(x.dl[0].quo[16:0]) : base + 21'(x.dl[0].quo[16:0]);
      hh = raw + 21'(cf.shift);
      if (hh[20]) begin
        hh = hh + 21'(HUE_FULL);
      end else if (hh >= 21'(HUE_FULL)) begin
        hh = hh - 21'(HUE_FULL);
      end
      y.h = hh[18:0];
    end else if (k == ST_PMUL) begin
      pm = 33'(x.d) * 33'(x.h[15:0]) + 33'd32768;
      y.p = pm[31:16];
    end else if (k == ST_REBUILD) begin
      mxx = {x.mx, x.mx};
      mm = {x.mn, x.mn};
      rise = mm + x.p;
      fall = mxx - x.p;
      unique case (x.h[18:16])
        3'd0: begin y.c[0] = mxx; y.c[1] = rise; y.c[2] = mm; end
        3'd1: begin y.c[0] = fall; y.c[1] = mxx; y.c[2] = mm; end
        3'd2: begin y.c[0] = mm; y.c[1] = mxx; y.c[2] = rise; end
        3'd3: begin y.c[0] = mm; y.c[1] = fall; y.c[2] = mxx; end
        3'd4: begin y.c[0] = rise; y.c[1] = mm; y.c[2] = mxx; end
        default: begin y.c[0] = mxx; y.c[1] = mm; y.c[2] = fall; end
      endcase
      y.v = 17'({1'b0, x.mx} + {1'b0, x.mn}) * 17'd257;
      dcap = (y.v < 17'd65535) ? y.v : 17'(ONE2) - y.v;
      kpos = 8'(8'd100 - 8'(cf.sat));
      kneg = 8'(8'd100 + 8'(cf.sat));
      if (!cf.sat[7]) begin
        lhs = 24'(x.d) * 24'd100;
        rhs = 24'(kpos) * 24'(dcap);
        if (lhs >= rhs) begin
          y.kk = dcap;
          y.den = {1'b0, x.d};
        end else begin
          y.kk = 17'(PCT_DEN);
          y.den = 17'(kpos);
        end
      end else begin
        y.kk = 17'(kneg);
        y.den = 17'(PCT_DEN);
      end
    end else if (k == ST_SMUL) begin
      for (int i = 0; i < 3; i++) begin
        e = {1'b0, x.c[i], 1'b0} - {1'b0, x.v};
        em = e[17] ? 18'd0 - e : e;
        y.dl[i].neg = e[17];
        y.prod[i] = 35'(em[16:0]) * 35'(x.kk);
      end
    end else if (k == ST_SSET) begin
      for (int i = 0; i < 3; i++) begin
        y.dl[i].num = 36'(x.prod[i]) + 36'(x.den[16:1]);
        y.dl[i].quo = '0;
      end
    end else if (k >= ST_SDIV && k < ST_SRES) begin
      y = div_steps(x, SAT_QW - 1 - DIV_STEPS * (k - ST_SDIV));
    end else if (k == ST_SRES) begin
      for (int i = 0; i < 3; i++) begin
        if (x.ach) begin
          y.t[i] = {chan(x, i), chan(x, i), 1'b0};
        end else begin
          tt = x.dl[i].neg ? {1'b0, x.v} - {1'b0, x.dl[i].quo[16:0]}
                           : {1'b0, x.v} + {1'b0, x.dl[i].quo[16:0]};
          y.t[i] = tt[16:0];
        end
      end
    end else if (k == ST_LMUL) begin
      lk = 8'(8'd100 + 8'(cf.lit));
      for (int i = 0; i < 3; i++) begin
        if (cf.lit[7] || cf.lit == 8'sd0) begin
          y.prod[i] = 35'(x.t[i]) * 35'(lk);
        end else begin
          y.prod[i] = 35'(17'(ONE2) - x.t[i]) * 35'(8'(cf.lit));
        end
      end
    end else if (k == ST_LSET) begin
      y.den = 17'(PCT_DEN);
      for (int i = 0; i < 3; i++) begin
        y.dl[i].num = 36'(x.prod[i]) + 36'(PCT_DEN / 2);
        y.dl[i].quo = '0;
        y.dl[i].neg = 1'b0;
      end
    end else if (k == ST_LDIV) begin
      for (int i = 0; i < 3; i++) begin
        lq = 49'(x.dl[i].num[23:0]) * 49'(LIT_RCP);
        y.dl[i].quo = 19'(lq[48:LIT_RSH]);
      end
    end else if (k == ST_LRES) begin
      for (int i = 0; i < 3; i++) begin
        if (cf.lit[7] || cf.lit == 8'sd0) begin
          y.t[i] = x.dl[i].quo[16:0];
        end else begin
          y.t[i] = 17'(19'(x.t[i]) + x.dl[i].quo);
        end
      end
    end else if (k == ST_BMUL) begin
      for (int i = 0; i < 3; i++) begin
        y.prod[i] = 35'(8'd255 - x.alpha) * 35'(ONE2) + 35'(x.t[i]) * 35'(x.alpha);
      end
    end else if (k == ST_BSET) begin
      y.den = 17'(ONE2);
      for (int i = 0; i < 3; i++) begin
        y.dl[i].num = 36'(x.prod[i]) + 36'(ONE2 / 2);
        y.dl[i].quo = '0;
      end
    end else if (k == ST_BDIV) begin
      for (int i = 0; i < 3; i++) begin
        bq = 53'(x.dl[i].num[25:0]) * 53'(BLD_RCP);
        y.dl[i].quo = 19'(bq[52:BLD_RSH]);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = x.dl[i].quo[9:0];
        lk = (q > 10'd255) ? 8'hFF : q[7:0];
        if (i == 0) begin
          y.red = lk;
        end else if (i == 1) begin
          y.green = lk;
        end else begin
          y.blue = lk;
        end
      end
    end
    return y;
  endfunction

endpackage

// ===== src/hsla_if.sv =====
interface hsla_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface hsla_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

interface hsla_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hsla_pkg::CFG_IDX_W-1:0]  index;
  logic [hsla_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/hsla_cfg.sv =====
module hsla_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  hsla_cfg_if.sink        cfg_i,
  output hsla_pkg::cfg_t  cfg_o
);

  logic [8:0]     hue_q;
  logic [7:0]     sat_q;
  logic [7:0]     lit_q;
  hsla_pkg::cfg_t cfg_d;
  hsla_pkg::cfg_t cfg_q;
  logic [8:0]     deg;
  logic [12:0]    x60;
  logic [27:0]    q60;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
      sat_q <= '0;
      lit_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        hsla_pkg::CFG_HUE: hue_q <= cfg_i.data;
        hsla_pkg::CFG_SAT: sat_q <= cfg_i.data[7:0];
        hsla_pkg::CFG_LIT: lit_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // The hue offset in 1/65536 sector units is 1092*deg + (16*deg + 30)/60.
  always_comb begin
    deg = hue_q[8] ? 9'(hue_q + 9'd360) : hue_q;
    x60 = {deg, 4'b0} + 13'd30;
    q60 = 28'(x60) * 28'd17477;
    cfg_d.shift = 19'(deg) * 19'd1092 + 19'(q60[27:20]);
    if ($signed(sat_q) < -8'sd100) begin
      cfg_d.sat = -8'sd100;
    end else if ($signed(sat_q) > 8'sd100) begin
      cfg_d.sat = 8'sd100;
    end else begin
      cfg_d.sat = $signed(sat_q);
    end
    if ($signed(lit_q) < -8'sd100) begin
      cfg_d.lit = -8'sd100;
    end else if ($signed(lit_q) > 8'sd100) begin
      cfg_d.lit = 8'sd100;
    end else begin
      cfg_d.lit = $signed(lit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/pixel_hue_saturation_lightness_adjust_top.sv =====
// Channel  Direction  Beat contents
// pix_i    in         red_in, green_in, blue_in, alpha_in
// pix_o    out        red_out, green_out, blue_out, alpha_out
// cfg_i    in         index (0 hue, 1 saturation, 2 lightness), data
//
// One pixel beat is accepted every cycle while no skid entry is held (pix_i.ready high).
// The hue and saturation steps use two bit-serial dividers, two quotient bits per stage,
// and the lightness and blend steps use reciprocal multiplies.
// Reset clears all valid bits and the configuration registers to zero.
// A stalled output holds its beat; one skid entry lets the pipeline take one more beat,
// then pix_i.ready stays low until the output beat is taken.
module pixel_hue_saturation_lightness_adjust_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  hsla_pix_in_if.sink     pix_i,
  hsla_pix_out_if.source  pix_o,
  hsla_cfg_if.sink        cfg_i
);

  hsla_pkg::cfg_t  cfg;
  hsla_pkg::pipe_t pipe_q [hsla_pkg::N_STAGES+1];
  hsla_pkg::pipe_t pipe_d;
  logic [hsla_pkg::N_STAGES:0] vld_q;
  logic            adv;
  logic            pop;
  logic            out_vld_q;
  logic            skid_vld_q;
  hsla_pkg::pix_t  out_q;
  hsla_pkg::pix_t  skid_q;
  hsla_pkg::pix_t  last;

  hsla_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign adv = !skid_vld_q;
  assign pop = out_vld_q && pix_o.ready;
  assign pix_i.ready = adv;

  always_comb begin
    pipe_d = '0;
    pipe_d.red = pix_i.red_in;
    pipe_d.green = pix_i.green_in;
    pipe_d.blue = pix_i.blue_in;
    pipe_d.alpha = pix_i.alpha_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[hsla_pkg::N_STAGES-1:0], pix_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= pipe_d;
      for (int k = 0; k < hsla_pkg::N_STAGES; k++) begin
        pipe_q[k+1] <= hsla_pkg::stage_fn(k, pipe_q[k], cfg);
      end
    end
  end

  always_comb begin
    last.red = pipe_q[hsla_pkg::N_STAGES].red;
    last.green = pipe_q[hsla_pkg::N_STAGES].green;
    last.blue = pipe_q[hsla_pkg::N_STAGES].blue;
    last.alpha = pipe_q[hsla_pkg::N_STAGES].alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= vld_q[hsla_pkg::N_STAGES];
      end else if (vld_q[hsla_pkg::N_STAGES]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b1;
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!out_vld_q || pop) begin
        out_q <= last;
      end else begin
        skid_q <= last;
      end
    end else if (pop) begin
      out_q <= skid_q;
    end
  end

  assign pix_o.valid = out_vld_q;
  assign pix_o.red_out = out_q.red;
  assign pix_o.green_out = out_q.green;
  assign pix_o.blue_out = out_q.blue;
  assign pix_o.alpha_out = out_q.alpha;

endmodule

// ===== dv/hsla_tb_if.sv =====
`timescale 1ns / 1ps

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  hsla_pix_in_if  pix_in ();
  hsla_pix_out_if pix_out ();
  hsla_cfg_if     cfg ();

  pixel_hue_saturation_lightness_adjust_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in.sink),
    .pix_o  (pix_out.source),
    .cfg_i  (cfg.sink)
  );

  logic [8:0] hue_reg;
  logic [7:0] sat_reg;
  logic [7:0] lit_reg;
  pixel_t expected_pixels[$];
  int mismatches;
  int pixels_checked;
  int pixels_sent;
  bit out_stall_enable;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint rounded_div(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp_percent(input logic [7:0] raw);
    longint p;
    p = longint'($signed(raw));
    if (p < -100) return -100;
    if (p > 100) return 100;
    return p;
  endfunction

  function automatic pixel_t adjust_pixel(input pixel_t px);
    pixel_t r;
    longint c[3];
    longint t[3];
    longint hmax, hmin, d, raw, h, p, rise, fall, v, dcap, kn, kd, deg, s, l, a, o;
    s = clamp_percent(sat_reg);
    l = clamp_percent(lit_reg);
    a = px.alpha;
    c[0] = px.red * 257;
    c[1] = px.green * 257;
    c[2] = px.blue * 257;
    hmax = c[0];
    hmin = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] > hmax) hmax = c[i];
      if (c[i] < hmin) hmin = c[i];
    end
    d = hmax - hmin;
    if (d == 0) begin
      for (int i = 0; i < 3; i++) t[i] = 2 * c[i];
    end else begin
      deg = longint'($signed(hue_reg)) % 360;
      if (deg < 0) deg += 360;
      if (c[0] == hmax) raw = rounded_div((c[1] - c[2]) * 65536, d);
      else if (c[1] == hmax) raw = 2 * 65536 + rounded_div((c[2] - c[0]) * 65536, d);
      else raw = 4 * 65536 + rounded_div((c[0] - c[1]) * 65536, d);
      h = (raw + (deg * 65536 + 30) / 60) % hsla_pkg::HUE_FULL;
      if (h < 0) h += hsla_pkg::HUE_FULL;
      p = (d * (h % 65536) + 32768) >>> 16;
      rise = hmin + p;
      fall = hmax - p;
      case (h >>> 16)
        0: begin c[0] = hmax; c[1] = rise; c[2] = hmin; end
        1: begin c[0] = fall; c[1] = hmax; c[2] = hmin; end
        2: begin c[0] = hmin; c[1] = hmax; c[2] = rise; end
        3: begin c[0] = hmin; c[1] = fall; c[2] = hmax; end
        4: begin c[0] = rise; c[1] = hmin; c[2] = hmax; end
        default: begin c[0] = hmax; c[1] = hmin; c[2] = fall; end
      endcase
      v = hmax + hmin;
      dcap = (v < 65535) ? v : hsla_pkg::ONE2 - v;
      if (s >= 0) begin
        if (100 * d >= (100 - s) * dcap || 100 - s <= 0) begin
          kn = dcap; kd = d;
        end else begin
          kn = 100; kd = 100 - s;
        end
      end else begin
        kn = 100 + s; kd = 100;
      end
      for (int i = 0; i < 3; i++) t[i] = v + rounded_div((2 * c[i] - v) * kn, kd);
    end
    for (int i = 0; i < 3; i++) begin
      if (l <= 0) t[i] = rounded_div(t[i] * (100 + l), 100);
      else t[i] = t[i] + rounded_div((hsla_pkg::ONE2 - t[i]) * l, 100);
      o = rounded_div((255 - a) * hsla_pkg::ONE2 + t[i] * a, hsla_pkg::ONE2);
      if (o < 0) o = 0;
      if (o > 255) o = 255;
      c[i] = o;
    end
    r.red = c[0][7:0];
    r.green = c[1][7:0];
    r.blue = c[2][7:0];
    r.alpha = px.alpha;
    return r;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_pixel(input pixel_t px, input bit gaps);
    int gap;
    gap = gaps ? random_gap() : 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in <= px.blue;
    pix_in.alpha_in <= px.alpha;
    do @(posedge clk_i); while (!pix_in.ready);
    expected_pixels.push_back(adjust_pixel(px));
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [hsla_pkg::CFG_IDX_W-1:0] idx,
                                input logic [8:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      hsla_pkg::CFG_HUE: hue_reg = value;
      hsla_pkg::CFG_SAT: sat_reg = value[7:0];
      default: lit_reg = value[7:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic configure(input int hue, input int sat, input int lit);
    wait_drained();
    write_register(hsla_pkg::CFG_HUE, 9'(hue));
    write_register(hsla_pkg::CFG_SAT, 9'(sat));
    write_register(hsla_pkg::CFG_LIT, 9'(lit));
    cfg.valid <= 1'b0;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red = 8'($urandom);
    px.green = 8'($urandom);
    px.blue = 8'($urandom);
    px.alpha = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF;
    if ($urandom_range(0, 15) == 0) begin
      px.green = px.red;
      px.blue = px.red;
    end
    return px;
  endfunction

  task automatic test_directed_extremes();
    pixel_t px;
    logic [7:0] vals[5] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
    configure(0, 0, 0);
    for (int i = 0; i < 5; i++) begin
      px = '{vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5], vals[(i + 3) % 5]};
      send_pixel(px, 0);
    end
    send_pixel('{8'h00, 8'h00, 8'h00, 8'hFF}, 0);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
    send_pixel('{8'h55, 8'h55, 8'h55, 8'h00}, 0);
    send_pixel('{8'hFF, 8'h00, 8'h00, 8'hFF}, 0);
    send_pixel('{8'h00, 8'hFF, 8'h00, 8'hFF}, 0);
    send_pixel('{8'h00, 8'h00, 8'hFF, 8'hFF}, 0);
    send_pixel('{8'hFF, 8'hFF, 8'h00, 8'h80}, 0);
    configure(180, 100, 100);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel(), 0);
    configure(-180, -100, -100);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel(), 0);
  endtask

  task automatic test_out_of_range_registers();
    configure(255, 127, -128);
    for (int i = 0; i < 40; i++) send_pixel(random_pixel(), 1);
    configure(-256, -128, 127);
    for (int i = 0; i < 40; i++) send_pixel(random_pixel(), 1);
    configure(359, 101, -101);
    for (int i = 0; i < 40; i++) send_pixel(random_pixel(), 1);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 16; phase++) begin
      configure($urandom_range(0, 360) - 180, $urandom_range(0, 200) - 100,
                $urandom_range(0, 200) - 100);
      out_stall_enable = (phase % 4 != 3);
      for (int i = 0; i < 100; i++) send_pixel(random_pixel(), phase % 4 != 2);
    end
    out_stall_enable = 1'b1;
  endtask

  initial begin
    int hold;
    hold = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pix_out.ready <= 1'b0;
        hold--;
      end else begin
        pix_out.ready <= 1'b1;
        if (out_stall_enable && $urandom_range(0, 2) == 0) hold = random_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat");
      end else begin
        automatic pixel_t want = expected_pixels.pop_front();
        if (pix_out.red_out !== want.red || pix_out.green_out !== want.green ||
            pix_out.blue_out !== want.blue || pix_out.alpha_out !== want.alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want.red, want.green, want.blue, want.alpha, pix_out.red_out,
                     pix_out.green_out, pix_out.blue_out, pix_out.alpha_out);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    cfg.valid = 1'b0;
    cfg.index = hsla_pkg::CFG_HUE;
    cfg.data = '0;
    hue_reg = '0;
    sat_reg = '0;
    lit_reg = '0;
    mismatches = 0;
    pixels_checked = 0;
    pixels_sent = 0;
    out_stall_enable = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_extremes();
    test_out_of_range_registers();
    test_random_settings();
    wait_drained();
    if (expected_pixels.size() != 0) mismatches++;
    $display("Sent %0d pixels over 22 register settings, %0d result beats checked.",
             pixels_sent, pixels_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
